// ----- hw/rtl/rfg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_pkg
// Shared types, constants and the linearization table of the glyph unit.
// ----------------------------------------------------------------------------
package rfg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_SHARPEN  = 3'd2,
    CFG_NEGATIVE = 3'd3,
    CFG_CONTRAST = 3'd4,
    CFG_LEVEL    = 3'd5,
    CFG_GLYPHS   = 3'd6
  } cfg_idx_e;

  localparam int CFG_DATA_W   = 11;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [15:0] W_RED     = 16'd13933;
  localparam logic [15:0] W_GREEN   = 16'd46873;
  localparam logic [15:0] W_BLUE    = 16'd4732;
  // floor(x/255) == (x*RECIP_255) >> RECIP_SHIFT for x <= 255*256
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic        sharpen;
    logic        negative;
    logic        contrast;
    logic [23:0] factor;
    logic [8:0]  glyph_count;
    logic        busy;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic [23:0] px;
  } job_t;

  typedef logic [15:0] lin_tab_t [256];

  // sRGB to linear light in Q0.16, evaluated at elaboration
  function automatic lin_tab_t build_lin();
    lin_tab_t    tab;
    logic [63:0] e;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] x2;
    logic [63:0] x4;
    logic [63:0] p;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        e = (64'(v) * 64'd6553600 + 64'd164730) / 64'd329460;
      end else begin
        t = (64'(1000 * v + 14025) << 32) / 64'd269025;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          x2   = (cand * cand) >> 32;
          x4   = (x2 * x2) >> 32;
          p    = (x4 * cand) >> 32;
          if (p <= t) r = cand;
        end
        e = (((t * t) >> 32) * ((r * r) >> 32)) >> 32;
        e = (e + 64'h8000) >> 16;
      end
      if (e > 64'd65535) e = 64'd65535;
      tab[v] = e[15:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();

endpackage

// ----- hw/rtl/rfg_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_cfg
// Configuration registers and the serial divider for the contrast factor.
// ----------------------------------------------------------------------------
module rfg_cfg import rfg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [2:0]            idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  localparam int NUM_W = 34;

  logic [10:0] width_q, height_q;
  logic        sharpen_q, negative_q, contrast_q;
  logic [23:0] factor_q;
  logic [8:0]  glyphs_q;
  logic        busy_q;
  logic [5:0]  step_q;
  logic [NUM_W-1:0] num_q;
  logic [17:0] rem_q, den_q;

  logic signed [10:0] lvl_s, lsum, ldiff;
  logic [17:0] num_hi, den_new;
  logic [18:0] rem_sh;
  logic        qbit;
  logic [17:0] rem_nxt;
  logic [NUM_W-1:0] num_nxt;

  always_comb begin
    lvl_s   = 11'(signed'(data_i[8:0]));
    lsum    = lvl_s + 11'sd255;
    ldiff   = 11'sd259 - lvl_s;
    // level -256 gives a negative numerator: factor saturates to zero
    num_hi  = lsum[10] ? 18'd0 : 18'(lsum[9:0]) * 18'd259;
    den_new = 18'(ldiff[9:0]) * 18'd255;
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    qbit    = rem_sh >= {1'b0, den_q};
    rem_nxt = qbit ? 18'(rem_sh - {1'b0, den_q}) : rem_sh[17:0];
    num_nxt = {num_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 11'd1024;
      height_q   <= 11'd1024;
      sharpen_q  <= 1'b0;
      negative_q <= 1'b0;
      contrast_q <= 1'b0;
      factor_q   <= 24'd65536;
      glyphs_q   <= 9'd10;
      busy_q     <= 1'b0;
      step_q     <= '0;
      num_q      <= '0;
      rem_q      <= '0;
      den_q      <= '0;
    end else begin
      if (we_i) begin
        unique case (idx_i)
          CFG_WIDTH:    width_q    <= data_i;
          CFG_HEIGHT:   height_q   <= data_i;
          CFG_SHARPEN:  sharpen_q  <= data_i[0];
          CFG_NEGATIVE: negative_q <= data_i[0];
          CFG_CONTRAST: contrast_q <= data_i[0];
          CFG_LEVEL: begin
            busy_q <= 1'b1;
            step_q <= '0;
            num_q  <= {num_hi, 16'd0};
            rem_q  <= '0;
            den_q  <= den_new;
          end
          CFG_GLYPHS:   glyphs_q   <= data_i[8:0];
          default: ;
        endcase
      end else if (busy_q) begin
        // one quotient bit per cycle while no register write comes in, restoring
        num_q  <= num_nxt;
        rem_q  <= rem_nxt;
        step_q <= step_q + 6'd1;
        if (step_q == 6'(NUM_W - 1)) begin
          busy_q   <= 1'b0;
          factor_q <= num_nxt[23:0];
        end
      end
    end
  end

  assign cfg_o = '{image_width: width_q, image_height: height_q, sharpen: sharpen_q,
                   negative: negative_q, contrast: contrast_q, factor: factor_q,
                   glyph_count: glyphs_q, busy: busy_q};

endmodule

// ----- hw/rtl/rfg_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module rfg_fifo import rfg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// ----- hw/rtl/rfg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_front
// Raster counters, two-row pixel store and sharpen; queues output jobs.
// ----------------------------------------------------------------------------
module rfg_front import rfg_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [23:0] data_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = CW + 1;

  typedef enum logic [2:0] {
    F_IDLE, F_RD_UP, F_RD_LF, F_RD_RT, F_CALC, F_PUSH_A, F_PUSH_B
  } state_e;

  state_e        state_q;
  logic [CW-1:0] col_q, c_q;
  logic [9:0]    row_q, r_q;
  logic [23:0]   cur_q, px_q, up_q, lf_q, rd_q, job_a_q;
  logic          last_row_q, last_col_q, sharp_q;
  logic [23:0]   mem_q [2**AW];

  logic [WW-1:0] w;
  logic [10:0]   h;
  logic [CW-1:0] c_eff;
  logic [9:0]    r_eff;
  logic [AW-1:0] rd_addr;
  logic          accept, c_end, r_end;
  logic [23:0]   sharp_px;
  logic signed [11:0] acc [3];

  always_comb begin
    w = (cfg_i.image_width == 11'd0) ? WW'(1) :
        ((32'(cfg_i.image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_i.image_width));
    h = (cfg_i.image_height == 11'd0) ? 11'd1 :
        ((32'(cfg_i.image_height) > HEIGHT_LIMIT) ? 11'(HEIGHT_LIMIT) : cfg_i.image_height);
    // hold counters at the last column or row after the size shrinks
    c_eff = (WW'(col_q) >= w) ? CW'(w - WW'(1)) : col_q;
    r_eff = ({1'b0, row_q} >= h) ? 10'(h - 11'd1) : row_q;
    c_end = WW'(c_eff) + WW'(1) == w;
    r_end = {1'b0, r_eff} + 11'd1 == h;
    accept  = (state_q == F_IDLE) && valid_i && !cfg_i.busy;
    ready_o = (state_q == F_IDLE) && !cfg_i.busy;

    unique case (state_q)
      F_RD_UP: rd_addr = {r_q[0], c_q};
      F_RD_LF: rd_addr = {~r_q[0], c_q - CW'(1)};
      F_RD_RT: rd_addr = {~r_q[0], c_q + CW'(1)};
      default: rd_addr = {~r_eff[0], c_eff};
    endcase

    for (int k = 0; k < 3; k++) begin
      acc[k] = 12'sd5 * $signed({4'd0, px_q[8*k +: 8]})
             - $signed({4'd0, lf_q[8*k +: 8]}) - $signed({4'd0, rd_q[8*k +: 8]})
             - $signed({4'd0, up_q[8*k +: 8]}) - $signed({4'd0, cur_q[8*k +: 8]});
      if (acc[k] < 0)             sharp_px[8*k +: 8] = 8'd0;
      else if (acc[k] > 12'sd255) sharp_px[8*k +: 8] = 8'd255;
      else                        sharp_px[8*k +: 8] = acc[k][7:0];
    end

    push_o = ((state_q == F_PUSH_A) || (state_q == F_PUSH_B)) && !full_i;
    job_o  = (state_q == F_PUSH_A) ? job_t'{last: 1'b0, px: job_a_q}
                                   : job_t'{last: last_col_q, px: cur_q};
  end

  // row store: one read and one write port, read data registered
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (state_q == F_CALC) mem_q[{r_q[0], c_q}] <= cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) cur_q <= data_i;
    if (state_q == F_RD_UP) px_q <= rd_q;
    if (state_q == F_RD_LF) up_q <= rd_q;
    if (state_q == F_RD_RT) lf_q <= rd_q;
    if (state_q == F_CALC)  job_a_q <= sharp_q ? sharp_px : px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      c_q        <= '0;
      r_q        <= '0;
      last_row_q <= 1'b0;
      last_col_q <= 1'b0;
      sharp_q    <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            state_q    <= F_RD_UP;
            c_q        <= c_eff;
            r_q        <= r_eff;
            last_row_q <= r_end;
            last_col_q <= c_end;
            sharp_q    <= cfg_i.sharpen && (r_eff >= 10'd2) && (c_eff != '0) && !c_end;
            if (c_end) begin
              col_q <= '0;
              row_q <= r_end ? 10'd0 : r_eff + 10'd1;
            end else begin
              col_q <= c_eff + CW'(1);
              row_q <= r_eff;
            end
          end
        end
        F_RD_UP: state_q <= F_RD_LF;
        F_RD_LF: state_q <= F_RD_RT;
        F_RD_RT: state_q <= F_CALC;
        F_CALC: begin
          if (r_q != 10'd0)    state_q <= F_PUSH_A;
          else if (last_row_q) state_q <= F_PUSH_B;
          else                 state_q <= F_IDLE;
        end
        F_PUSH_A: if (!full_i) state_q <= last_row_q ? F_PUSH_B : F_IDLE;
        F_PUSH_B: if (!full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rfg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_back
// Color pipeline: negative, contrast, luminance, gamma search, glyph index.
// ----------------------------------------------------------------------------
module rfg_back import rfg_pkg::*; #(
  parameter int GAMMA_TABLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  glyph_o,
  output logic [7:0]  gray_o,
  output logic        last_o
);

  localparam logic [15:0] LOW_MASK = 16'((32'd1 << (16 - GAMMA_TABLE_BITS)) - 32'd1);

  logic adv;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v14_q, v15_q, vo_q;
  logic l1_q, l2_q, l3_q, l4_q, l5_q, l14_q, l15_q, lo_q;
  logic [7:0]  ch1_q [3];
  logic [7:0]  ch2_q [3];
  logic signed [34:0] s2_q [3];
  logic [15:0] lin3_q [3];
  logic [31:0] p4_q [3];
  logic [15:0] lv5_q;
  logic        sv_q [8];
  logic        sl_q [8];
  logic [7:0]  sg_q [8];
  logic [15:0] slv_q [8];
  logic [7:0]  g14_q, g15_q, go_q;
  logic [15:0] gc14_q;
  logic [31:0] q15_q;
  logic [7:0]  idx_q;

  logic [8:0]  cnt, cnt_m1, qv;
  logic signed [33:0] cprod [3];
  logic [7:0]  ch3 [3];
  logic [33:0] wsum;
  logic [15:0] lum;
  logic [7:0]  g_in [8];
  logic [15:0] lv_in [8];
  logic        v_in [8];
  logic        l_in [8];
  logic [7:0]  g_nx [8];

  always_comb begin
    adv   = !vo_q || ready_i;
    pop_o = adv && !empty_i;
    cnt   = (cfg_i.glyph_count == 9'd0) ? 9'd1 :
            ((cfg_i.glyph_count > 9'd256) ? 9'd256 : cfg_i.glyph_count);
    cnt_m1 = cnt - 9'd1;
    for (int k = 0; k < 3; k++) begin
      cprod[k] = $signed({1'b0, cfg_i.factor}) * ($signed({1'b0, ch1_q[k]}) - 9'sd128);
      if (!cfg_i.contrast)      ch3[k] = ch2_q[k];
      else if (s2_q[k] < 0)     ch3[k] = 8'd0;
      else if (s2_q[k][34:16] > 19'd255) ch3[k] = 8'd255;
      else                      ch3[k] = s2_q[k][23:16];
    end
    wsum = 34'(p4_q[0]) + 34'(p4_q[1]) + 34'(p4_q[2]);
    lum  = (wsum[33:16] > 18'd65535) ? 16'hFFFF : wsum[31:16];
    // binary search for the largest g with LIN_TAB[g] <= lv
    g_in[0]  = 8'd0;
    lv_in[0] = lv5_q;
    v_in[0]  = v5_q;
    l_in[0]  = l5_q;
    for (int k = 1; k < 8; k++) begin
      g_in[k]  = sg_q[k-1];
      lv_in[k] = slv_q[k-1];
      v_in[k]  = sv_q[k-1];
      l_in[k]  = sl_q[k-1];
    end
    for (int k = 0; k < 8; k++) begin
      g_nx[k]  = (LIN_TAB[g_in[k] | (8'd128 >> k)] <= lv_in[k]) ?
                 (g_in[k] | (8'd128 >> k)) : g_in[k];
    end
    qv = q15_q[RECIP_SHIFT +: 9];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ch1_q[k]  <= cfg_i.negative ? ~job_i.px[8*k +: 8] : job_i.px[8*k +: 8];
        ch2_q[k]  <= ch1_q[k];
        s2_q[k]   <= 35'(cprod[k]) + 35'sd8388608;
        lin3_q[k] <= LIN_TAB[ch3[k]];
      end
      p4_q[0] <= 32'(lin3_q[0]) * 32'(W_RED);
      p4_q[1] <= 32'(lin3_q[1]) * 32'(W_GREEN);
      p4_q[2] <= 32'(lin3_q[2]) * 32'(W_BLUE);
      lv5_q   <= lum | LOW_MASK;
      for (int k = 0; k < 8; k++) begin
        sg_q[k]  <= g_nx[k];
        slv_q[k] <= lv_in[k];
      end
      g14_q  <= sg_q[7];
      gc14_q <= 16'(sg_q[7]) * 16'(cnt);
      g15_q  <= g14_q;
      q15_q  <= 32'(gc14_q) * 32'(RECIP_255);
      go_q   <= g15_q;
      idx_q  <= (qv > cnt_m1) ? cnt_m1[7:0] : qv[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v14_q, v15_q, vo_q} <= '0;
      {l1_q, l2_q, l3_q, l4_q, l5_q, l14_q, l15_q, lo_q} <= '0;
      for (int k = 0; k < 8; k++) begin
        sv_q[k] <= 1'b0;
        sl_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_q <= !empty_i;    l1_q <= job_i.last;
      v2_q <= v1_q;        l2_q <= l1_q;
      v3_q <= v2_q;        l3_q <= l2_q;
      v4_q <= v3_q;        l4_q <= l3_q;
      v5_q <= v4_q;        l5_q <= l4_q;
      for (int k = 0; k < 8; k++) begin
        sv_q[k] <= v_in[k];
        sl_q[k] <= l_in[k];
      end
      v14_q <= sv_q[7];    l14_q <= sl_q[7];
      v15_q <= v14_q;      l15_q <= l14_q;
      vo_q  <= v15_q;      lo_q  <= l15_q;
    end
  end

  assign valid_o = vo_q;
  assign glyph_o = idx_q;
  assign gray_o  = go_q;
  assign last_o  = lo_q;

endmodule

// ----- hw/rtl/rgb_filter_to_gray_glyph_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_filter_to_gray_glyph_unit
// RGB pixel stream in, one glyph index and gray level per pixel out.
// ----------------------------------------------------------------------------
// Input pacing: a new pixel is taken only after the front has finished the last
//   one. The row store with its one read port (four reads a pixel) and the
//   job pushes into the queue (none on the first row, one on middle rows, two
//   on the last row, one when the frame has a single row) set the pace.
// Writing contrast_level blocks input while the serial divider runs.
// Reset restores the register defaults; the row store is not cleared.
// ----------------------------------------------------------------------------
module rgb_filter_to_gray_glyph_unit import rfg_pkg::*; #(
  parameter int MAX_WIDTH        = 1024,
  parameter int GAMMA_TABLE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // red, green, blue
  // glyph output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // glyph_index, gray_value
  output logic                  m_axis_tlast    // frame_end
);

  cfg_t cfg;
  logic push, pop, full, empty;
  job_t job_in, job_out;

  rfg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // front: row store, sharpen, none, one or two jobs per word
  rfg_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full)
  );

  // decouple front and back so each can stall on its own
  rfg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: color math and glyph quantization, stalls as one pipeline
  rfg_back #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .glyph_o (m_axis_tdata[7:0]),
    .gray_o  (m_axis_tdata[15:8]),
    .last_o  (m_axis_tlast)
  );

  // a pixel passes through the read and calc states: no word right after accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("job popped from empty queue");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.busy |-> !s_axis_tready)
    else $error("input taken while factor divider runs");

endmodule

// ----- tb/tb_rgb_filter_to_gray_glyph_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_filter_to_gray_glyph_unit
// Self-checking bench for the RGB to gray glyph unit. Whole frames of pixels
// are streamed in under many register settings. A local line buffer, color
// chain and luminance tables predict every output word, and each one is
// compared in order with what the unit emits. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb_rgb_filter_to_gray_glyph_unit import rfg_pkg::*; ();

  localparam int        MAX_W      = 1024;
  localparam int        GAMMA_BITS = 12;
  localparam int        GAMMA_N    = 1 << GAMMA_BITS;
  // index past the last register; the unit must ignore writes to it
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int        DRAIN_CYC  = 40;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] gray;
    logic       frame_end;
  } glyph_word_t;

  // directed stimulus; a known row carries its typed-in result
  typedef struct {
    logic [23:0] px;
    bit          known;
    logic [7:0]  glyph;
    logic [7:0]  gray;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  rgb_filter_to_gray_glyph_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // red, green, blue
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // glyph_index, gray_value
    .m_axis_tlast  (m_axis_tlast)    // frame_end
  );

  // --------------------------------------------------------------------------
  // Predictor state: register mirror, raster position, line buffer, tables
  // --------------------------------------------------------------------------
  logic [10:0] img_w, img_h;
  logic        sharpen_on, negative_on, contrast_on;
  logic [8:0]  glyph_levels;
  logic [31:0] stretch_q16;
  int unsigned col_pos, row_pos;
  logic [23:0] line_buf [2*MAX_W];
  logic [15:0] lin_lut [256];
  logic [7:0]  gamma_lut [GAMMA_N];

  glyph_word_t glyph_q[$];
  int          err_count;
  bit          sink_quiet;   // no stalls in the last part of the run
  bit          src_quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[rgb_filter_to_gray_glyph_unit] ERROR");
    $finish;
  end

  // sRGB linearization (Q0.16) and its inverse as a gamma lookup
  function automatic void build_luma_tables();
    longint unsigned e, t, r, cand, x2, x4, lv;
    int unsigned     g;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        e = (longint'(v) * 6553600 + 164730) / 329460;
      end else begin
        t = (longint'(1000 * v + 14025) << 32) / 269025;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          x2   = (cand * cand) >> 32;
          x4   = (x2 * x2) >> 32;
          if (((x4 * cand) >> 32) <= t) r = cand;
        end
        e = (((t * t) >> 32) * ((r * r) >> 32)) >> 32;
        e = (e + 64'h8000) >> 16;
      end
      if (e > 65535) e = 65535;
      lin_lut[v] = e[15:0];
    end
    g = 0;
    for (int i = 0; i < GAMMA_N; i++) begin
      lv = ((i + 1) << (16 - GAMMA_BITS)) - 1;
      while (g < 255 && lin_lut[g+1] <= lv) g++;
      gamma_lut[i] = g[7:0];
    end
  endfunction

  function automatic logic [7:0] stretch_channel(logic [7:0] v);
    longint s;
    s = longint'(stretch_q16) * (longint'(v) - 128) + (longint'(128) << 16);
    if (s < 0) return 8'd0;
    if ((s >>> 16) > 255) return 8'd255;
    return s[23:16];
  endfunction

  function automatic glyph_word_t pixel_to_glyph(logic [23:0] px, logic frame_end);
    glyph_word_t     w;
    logic [7:0]      ch [3];
    longint unsigned luma;
    int unsigned     levels, gray, idx;
    for (int k = 0; k < 3; k++) begin
      ch[k] = px[8*k +: 8];
      if (negative_on) ch[k] = 8'd255 - ch[k];
      if (contrast_on) ch[k] = stretch_channel(ch[k]);
    end
    luma = (64'd13933 * lin_lut[ch[0]] + 64'd46873 * lin_lut[ch[1]]
          + 64'd4732 * lin_lut[ch[2]]) >> 16;
    if (luma > 65535) luma = 65535;
    gray   = gamma_lut[luma >> (16 - GAMMA_BITS)];
    levels = (glyph_levels == 0) ? 1 : (glyph_levels > 256 ? 256 : glyph_levels);
    idx    = gray * levels / 255;
    if (idx > levels - 1) idx = levels - 1;
    w.glyph     = idx[7:0];
    w.gray      = gray[7:0];
    w.frame_end = frame_end;
    return w;
  endfunction

  function automatic int unsigned eff_width();
    return (img_w == 0) ? 1 : (img_w > MAX_W ? MAX_W : img_w);
  endfunction

  function automatic int unsigned eff_height();
    return (img_h == 0) ? 1 : (img_h > HEIGHT_LIMIT ? HEIGHT_LIMIT : img_h);
  endfunction

  // advance the raster by one accepted pixel and queue the words it releases
  function automatic void predict_pixel(logic [23:0] cur);
    int unsigned w, h, c, r, cb, pb;
    logic [23:0] px, up, lf, rt;
    int          x;
    w  = eff_width();
    h  = eff_height();
    c  = (col_pos >= w) ? w - 1 : col_pos;
    r  = (row_pos >= h) ? h - 1 : row_pos;
    cb = (r & 1) * MAX_W;
    pb = ((r + 1) & 1) * MAX_W;
    if (r >= 1) begin
      px = line_buf[pb + c];
      // cross kernel on interior pixels only; borders pass unchanged
      if (sharpen_on && r >= 2 && c >= 1 && c + 1 < w) begin
        up = line_buf[cb + c];
        lf = line_buf[pb + c - 1];
        rt = line_buf[pb + c + 1];
        for (int k = 0; k < 3; k++) begin
          x = 5 * int'(px[8*k +: 8]) - int'(lf[8*k +: 8]) - int'(rt[8*k +: 8])
            - int'(up[8*k +: 8]) - int'(cur[8*k +: 8]);
          px[8*k +: 8] = (x < 0) ? 8'd0 : (x > 255 ? 8'd255 : x[7:0]);
        end
      end
      glyph_q.push_back(pixel_to_glyph(px, 1'b0));
    end
    line_buf[cb + c] = cur;
    // last row: emit the pixel itself right after the one above it
    if (r == h - 1) glyph_q.push_back(pixel_to_glyph(cur, c == w - 1));
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void mirror_cfg(logic [2:0] idx, logic [10:0] data);
    longint lvl, num, den;
    case (idx)
      CFG_WIDTH:    img_w        = data;
      CFG_HEIGHT:   img_h        = data;
      CFG_SHARPEN:  sharpen_on   = data[0];
      CFG_NEGATIVE: negative_on  = data[0];
      CFG_CONTRAST: contrast_on  = data[0];
      CFG_LEVEL: begin
        lvl = longint'($signed(data[8:0]));
        num = 259 * (lvl + 255) * 65536;
        den = 255 * (259 - lvl);
        // a level of -256 drives the factor to zero
        stretch_q16 = (num < 0) ? 32'd0 : 32'(num / den);
      end
      CFG_GLYPHS:   glyph_levels = data[8:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one write, then the enable drops low before the next write
  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mirror_cfg(idx, data);
    @(posedge clk_i);
  endtask

  // hold until every queued word has drained and the pipe is empty
  task automatic wait_idle();
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // present one pixel word and hold it until accepted; returns on the edge
  task automatic send_pixel(logic [23:0] px);
    if (!src_quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(px);
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    px = 24'($urandom);
    case ($urandom_range(0, 9))
      0: px = 24'h000000;
      1: px = 24'hFFFFFF;
      2: px[7:0] = 8'($urandom_range(0, 1) * 255);
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_frame();
    int unsigned n;
    n = eff_width() * eff_height();
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic rand_setup(int unsigned w, int unsigned h);
    logic [8:0] lvl;
    case ($urandom_range(0, 5))
      0: lvl = 9'h100;   // -256
      1: lvl = 9'h101;   // -255
      2: lvl = 9'd255;
      3: lvl = 9'd0;
      default: lvl = 9'($urandom);
    endcase
    write_reg(CFG_WIDTH, 11'(w));
    write_reg(CFG_HEIGHT, 11'(h));
    write_reg(CFG_SHARPEN, 11'($urandom_range(0, 1)));
    write_reg(CFG_NEGATIVE, 11'($urandom_range(0, 1)));
    write_reg(CFG_CONTRAST, 11'($urandom_range(0, 2) != 0));
    if ($urandom_range(0, 1)) write_reg(CFG_LEVEL, {2'b00, lvl});
    case ($urandom_range(0, 4))
      0: write_reg(CFG_GLYPHS, 11'($urandom_range(0, 1)));
      1: write_reg(CFG_GLYPHS, 11'd256);
      2: write_reg(CFG_GLYPHS, 11'($urandom_range(257, 511)));
      default: write_reg(CFG_GLYPHS, 11'($urandom_range(2, 255)));
    endcase
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 11'($urandom));
  endtask

  // sink side: random stall bursts until the quiet tail
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!sink_quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted output word with the oldest expectation
  always @(posedge clk_i) begin
    glyph_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (glyph_q.size() == 0) begin
        $display("%0t: unexpected word glyph=%0d gray=%0d last=%0b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        err_count++;
      end else begin
        exp_w = glyph_q.pop_front();
        if (m_axis_tdata[7:0] !== exp_w.glyph) begin
          $display("%0t: glyph_index expected %0d actual %0d", $time,
                   exp_w.glyph, m_axis_tdata[7:0]);
          err_count++;
        end
        if (m_axis_tdata[15:8] !== exp_w.gray) begin
          $display("%0t: gray_value expected %0d actual %0d", $time,
                   exp_w.gray, m_axis_tdata[15:8]);
          err_count++;
        end
        if (m_axis_tlast !== exp_w.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time,
                   exp_w.frame_end, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pixel_row_t  dir_rows [16];
    glyph_word_t typed;
    int          rand_items;
    int unsigned w, h;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_count     = 0;
    sink_quiet    = 1'b0;
    src_quiet     = 1'b0;
    img_w = 11'd1024; img_h = 11'd1024;
    sharpen_on = 1'b0; negative_on = 1'b0; contrast_on = 1'b0;
    glyph_levels = 9'd10; stretch_q16 = 32'd65536;
    col_pos = 0; row_pos = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
    build_luma_tables();

    // first eight rows: reset color path, ten levels; last eight: negative,
    // 256 levels. Black and white read straight off the ramp ends.
    dir_rows = '{
      '{24'h000000, 1, 8'd0,   8'd0},   '{24'hFFFFFF, 1, 8'd9,   8'd255},
      '{24'h0000FF, 0, 0, 0},           '{24'h00FF00, 0, 0, 0},
      '{24'hFF0000, 0, 0, 0},           '{24'h808080, 0, 0, 0},
      '{24'h55AA33, 0, 0, 0},           '{24'hAA55CC, 0, 0, 0},
      '{24'h000000, 1, 8'd255, 8'd255}, '{24'hFFFFFF, 1, 8'd0,   8'd0},
      '{24'h010101, 0, 0, 0},           '{24'hFEFEFE, 0, 0, 0},
      '{24'h0A0B0C, 0, 0, 0},           '{24'h7F7F7F, 0, 0, 0},
      '{24'hC0FFEE, 0, 0, 0},           '{24'h3F00FF, 0, 0, 0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-row frames: every pixel releases itself at once
    write_reg(CFG_WIDTH, 11'd8);
    write_reg(CFG_HEIGHT, 11'd1);
    for (int i = 0; i < 16; i++) begin
      if (i == 8) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(CFG_NEGATIVE, 11'd1);
        write_reg(CFG_GLYPHS, 11'd256);
      end
      send_pixel(dir_rows[i].px);
      if (dir_rows[i].known) begin
        typed = glyph_q.pop_back();
        typed.glyph = dir_rows[i].glyph;
        typed.gray  = dir_rows[i].gray;
        glyph_q.push_back(typed);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // flat gray through a zero contrast factor, then a sharpened 3x3
    write_reg(CFG_NEGATIVE, 11'd0);
    write_reg(CFG_CONTRAST, 11'd1);
    write_reg(CFG_LEVEL, 11'h100);
    write_reg(CFG_HEIGHT, 11'd2);
    send_frame();
    wait_idle();
    write_reg(CFG_CONTRAST, 11'd0);
    write_reg(CFG_SHARPEN, 11'd1);
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd3);
    send_frame();
    wait_idle();

    // size extremes: zero width and height act as one
    rand_setup(0, 0);
    send_frame();
    wait_idle();

    // random frames, mostly small and often tall enough to sharpen
    rand_items = 0;
    while (rand_items < 820) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      src_quiet  = (rand_items > 700) || ($urandom_range(0, 4) == 0);
      sink_quiet = (rand_items > 700);
      rand_setup(w, h);
      send_frame();
      rand_items += eff_width() * eff_height();
      wait_idle();
    end

    if (glyph_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, glyph_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("[rgb_filter_to_gray_glyph_unit] OK");
    end else begin
      $display("[rgb_filter_to_gray_glyph_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rfg_pkg.sv
hw/rtl/rfg_cfg.sv
hw/rtl/rfg_fifo.sv
hw/rtl/rfg_front.sv
hw/rtl/rfg_back.sv
hw/rtl/rgb_filter_to_gray_glyph_unit.sv
tb/tb_rgb_filter_to_gray_glyph_unit.sv
